// ===== src/tiled_gradient_noise_2d_assert.svh =====
// Assertion macros used by the top-level design file.
`ifndef TILED_GRADIENT_NOISE_2D_ASSERT_SVH
`define TILED_GRADIENT_NOISE_2D_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TGN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tgn assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TGN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tgn assertion failed");

`endif

// ===== src/tgn_pkg.sv =====
package tgn_pkg;

	localparam int COORD_W = 32;
	localparam int CFG_W   = 9;
	localparam int OUT_W   = 19;

	localparam logic [CFG_W-1:0] TILE_RESET = 9'd5;
	localparam logic [CFG_W-1:0] TILE_MIN   = 9'd1;
	localparam logic [CFG_W-1:0] TILE_MAX   = 9'd256;

	// Low four hash bits of the four cell corners.
	typedef struct packed {
		logic [3:0] h00;
		logic [3:0] h10;
		logic [3:0] h01;
		logic [3:0] h11;
	} hash4_t;

	localparam logic [7:0] PERM [256] = '{
		8'd200, 8'd35, 8'd82, 8'd243, 8'd87, 8'd134, 8'd68, 8'd179,
		8'd7, 8'd14, 8'd85, 8'd64, 8'd55, 8'd83, 8'd46, 8'd151,
		8'd214, 8'd95, 8'd161, 8'd19, 8'd112, 8'd69, 8'd194, 8'd56,
		8'd204, 8'd65, 8'd79, 8'd140, 8'd241, 8'd57, 8'd203, 8'd136,
		8'd119, 8'd137, 8'd187, 8'd150, 8'd28, 8'd192, 8'd228, 8'd217,
		8'd73, 8'd222, 8'd178, 8'd105, 8'd0, 8'd103, 8'd202, 8'd133,
		8'd110, 8'd242, 8'd235, 8'd115, 8'd164, 8'd25, 8'd183, 8'd248,
		8'd113, 8'd195, 8'd84, 8'd163, 8'd147, 8'd61, 8'd210, 8'd197,
		8'd122, 8'd201, 8'd108, 8'd21, 8'd227, 8'd173, 8'd117, 8'd246,
		8'd96, 8'd182, 8'd88, 8'd66, 8'd138, 8'd238, 8'd186, 8'd148,
		8'd185, 8'd31, 8'd44, 8'd181, 8'd77, 8'd234, 8'd29, 8'd152,
		8'd239, 8'd158, 8'd237, 8'd100, 8'd116, 8'd26, 8'd6, 8'd2,
		8'd53, 8'd193, 8'd10, 8'd30, 8'd174, 8'd229, 8'd45, 8'd71,
		8'd51, 8'd253, 8'd198, 8'd153, 8'd43, 8'd128, 8'd213, 8'd13,
		8'd209, 8'd212, 8'd224, 8'd189, 8'd114, 8'd93, 8'd132, 8'd165,
		8'd142, 8'd76, 8'd90, 8'd143, 8'd32, 8'd9, 8'd131, 8'd127,
		8'd233, 8'd157, 8'd223, 8'd11, 8'd118, 8'd8, 8'd221, 8'd231,
		8'd156, 8'd92, 8'd252, 8'd15, 8'd199, 8'd5, 8'd50, 8'd191,
		8'd107, 8'd226, 8'd39, 8'd180, 8'd251, 8'd27, 8'd219, 8'd1,
		8'd12, 8'd139, 8'd188, 8'd240, 8'd99, 8'd244, 8'd155, 8'd41,
		8'd126, 8'd109, 8'd225, 8'd145, 8'd23, 8'd250, 8'd236, 8'd121,
		8'd220, 8'd169, 8'd177, 8'd62, 8'd144, 8'd168, 8'd159, 8'd190,
		8'd70, 8'd120, 8'd249, 8'd232, 8'd47, 8'd42, 8'd94, 8'd149,
		8'd60, 8'd36, 8'd20, 8'd78, 8'd124, 8'd4, 8'd135, 8'd91,
		8'd130, 8'd97, 8'd75, 8'd154, 8'd208, 8'd48, 8'd54, 8'd215,
		8'd18, 8'd146, 8'd17, 8'd167, 8'd38, 8'd34, 8'd141, 8'd171,
		8'd74, 8'd33, 8'd172, 8'd104, 8'd40, 8'd175, 8'd170, 8'd52,
		8'd184, 8'd207, 8'd125, 8'd176, 8'd218, 8'd67, 8'd245, 8'd49,
		8'd101, 8'd86, 8'd80, 8'd37, 8'd98, 8'd106, 8'd211, 8'd166,
		8'd89, 8'd196, 8'd216, 8'd58, 8'd63, 8'd230, 8'd205, 8'd81,
		8'd16, 8'd123, 8'd129, 8'd24, 8'd247, 8'd22, 8'd111, 8'd72,
		8'd206, 8'd255, 8'd254, 8'd160, 8'd162, 8'd102, 8'd3, 8'd59
	};

endpackage

// ===== src/tgn_point_if.sv =====
interface tgn_point_if;
	logic                         valid;
	logic                         ready;
	logic [tgn_pkg::COORD_W-1:0] coord_x;
	logic [tgn_pkg::COORD_W-1:0] coord_y;

	modport source (output valid, output coord_x, output coord_y, input ready);
	modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

// ===== src/tgn_result_if.sv =====
interface tgn_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [tgn_pkg::OUT_W-1:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

// ===== src/tgn_mod.sv =====
// Pipelined remainder of an unsigned cell index by the tile width, four bits a stage.
module tgn_mod #(
	parameter int IW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [8:0]    tile_w,
	input  logic [IW-1:0] idx,
	output logic [7:0]    rem
);
	localparam int NS = (IW + 3) / 4;
	localparam int PW = NS * 4;

	logic [PW-1:0] num_s [NS-1];
	logic [7:0]    rem_s [NS];
	logic [PW-1:0] pad;

	function automatic logic [7:0] step4(input logic [7:0] r, input logic [3:0] nib,
		input logic [8:0] w);
		logic [8:0] t;
		logic [7:0] acc;
		acc = r;
		for (int b = 3; b >= 0; b--) begin
			t = {acc, nib[b]};
			if (t >= w) t = t - w;
			acc = t[7:0];
		end
		return acc;
	endfunction

	assign pad = PW'(idx);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= step4(8'd0, pad[PW-1 -: 4], tile_w);
			num_s[0] <= pad << 4;
			for (int j = 1; j < NS; j++) begin
				rem_s[j] <= step4(rem_s[j-1], num_s[j-1][PW-1 -: 4], tile_w);
				if (j < NS - 1) num_s[j] <= num_s[j-1] << 4;
			end
		end
	end

	assign rem = rem_s[NS-1];
endmodule

// ===== src/tgn_fade.sv =====
// Quintic fade 6t^5-15t^4+10t^3 in three multiply stages.
module tgn_fade #(
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [F-1:0] t,
	output logic [F:0]   fade
);
	localparam int PW = F + 5;

	logic [F-1:0]   t_s1, s_s1, c_s2;
	logic [F+3:0]   p_s2;
	logic [F:0]     f_s3;
	logic [2*F-1:0] sq, cu;
	logic [PW-1:0]  poly;
	logic [2*F+3:0] fp;

	assign sq   = t * t;
	assign cu   = s_s1 * t_s1;
	assign poly = PW'(s_s1) * PW'(6) + (PW'(10) << F) - PW'(t_s1) * PW'(15);
	assign fp   = c_s2 * p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			s_s1 <= sq[2*F-1:F];
			c_s2 <= cu[2*F-1:F];
			p_s2 <= poly[F+3:0];
			f_s3 <= fp[2*F:F];
		end
	end

	assign fade = f_s3;
endmodule

// ===== src/tgn_hash.sv =====
// Corner wrap and two permutation lookups for the four cell corners.
module tgn_hash (
	input  logic                clk,
	input  logic                en,
	input  logic [8:0]          tile_w,
	input  logic [7:0]          x0,
	input  logic [7:0]          y0,
	output tgn_pkg::hash4_t     hash
);
	logic [7:0]      x0_s1, x1_s1, y0_s1, y1_s1;
	logic [7:0]      px0_s2, px1_s2, y0_s2, y1_s2;
	tgn_pkg::hash4_t h_s3;
	logic [8:0]      xn, yn;
	logic [7:0]      i00, i10, i01, i11;

	assign xn = {1'b0, x0} + 9'd1;
	assign yn = {1'b0, y0} + 9'd1;

	assign i00 = px0_s2 + y0_s2;
	assign i10 = px1_s2 + y0_s2;
	assign i01 = px0_s2 + y1_s2;
	assign i11 = px1_s2 + y1_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1 <= x0;
			y0_s1 <= y0;
			x1_s1 <= (xn == tile_w) ? 8'd0 : xn[7:0];
			y1_s1 <= (yn == tile_w) ? 8'd0 : yn[7:0];
			px0_s2 <= tgn_pkg::PERM[x0_s1];
			px1_s2 <= tgn_pkg::PERM[x1_s1];
			y0_s2 <= y0_s1;
			y1_s2 <= y1_s1;
			h_s3.h00 <= tgn_pkg::PERM[i00][3:0];
			h_s3.h10 <= tgn_pkg::PERM[i10][3:0];
			h_s3.h01 <= tgn_pkg::PERM[i01][3:0];
			h_s3.h11 <= tgn_pkg::PERM[i11][3:0];
		end
	end

	assign hash = h_s3;
endmodule

// ===== src/tgn_blend.sv =====
// Corner gradients, then the x blend of both rows and the y blend, with saturation.
module tgn_blend #(
	parameter int F = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  tgn_pkg::hash4_t                   hash,
	input  logic [F-1:0]                      fx,
	input  logic [F-1:0]                      fy,
	input  logic [F:0]                        wx,
	input  logic [F:0]                        wy,
	output logic signed [tgn_pkg::OUT_W-1:0] noise
);
	localparam int DW = F + 2;
	localparam int GW = F + 3;
	localparam int MW = 2 * F + 6;
	localparam int SW = (GW > tgn_pkg::OUT_W) ? GW : tgn_pkg::OUT_W;
	localparam logic signed [SW-1:0] SMAX = SW'(262143);
	localparam logic signed [SW-1:0] SMIN = SW'(-262144);
	localparam logic signed [DW-1:0] ONE  = DW'(1) << F;

	logic signed [GW-1:0] g00_s1, g10_s1, g01_s1, g11_s1;
	logic [F:0]           wx_s1, wy_s1, wy_s2, wy_s3;
	logic signed [MW-1:0] p0_s2, p1_s2, pn_s4;
	logic signed [GW-1:0] a0_s2, a1_s2, r0_s3, r1_s3, a_s4;
	logic signed [tgn_pkg::OUT_W-1:0] n_s5;
	logic signed [DW-1:0] dx0, dx1, dy0, dy1;
	logic signed [GW-1:0] n_full;
	logic signed [SW-1:0] n_ext;

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
		logic signed [GW-1:0] u, v;
		u = (h < 4'd8) ? GW'(dx) : GW'(dy);
		v = (h < 4'd4) ? GW'(dy) : GW'(dx);
		if (h[0]) u = -u;
		if (h[1]) v = -v;
		return u + v;
	endfunction

	assign dx0 = signed'(DW'(fx));
	assign dy0 = signed'(DW'(fy));
	assign dx1 = dx0 - ONE;
	assign dy1 = dy0 - ONE;

	assign n_full = a_s4 + GW'(pn_s4 >>> F);
	assign n_ext  = SW'(n_full);

	always_ff @(posedge clk) begin
		if (en) begin
			g00_s1 <= grad(hash.h00, dx0, dy0);
			g10_s1 <= grad(hash.h10, dx1, dy0);
			g01_s1 <= grad(hash.h01, dx0, dy1);
			g11_s1 <= grad(hash.h11, dx1, dy1);
			wx_s1  <= wx;
			wy_s1  <= wy;

			p0_s2 <= signed'({1'b0, wx_s1}) * (GW'(g10_s1) - GW'(g00_s1) + (GW+1)'(0));
			p1_s2 <= signed'({1'b0, wx_s1}) * (GW'(g11_s1) - GW'(g01_s1) + (GW+1)'(0));
			a0_s2 <= g00_s1;
			a1_s2 <= g01_s1;
			wy_s2 <= wy_s1;

			r0_s3 <= a0_s2 + GW'(p0_s2 >>> F);
			r1_s3 <= a1_s2 + GW'(p1_s2 >>> F);
			wy_s3 <= wy_s2;

			pn_s4 <= signed'({1'b0, wy_s3}) * (r1_s3 - r0_s3 + (GW+1)'(0));
			a_s4  <= r0_s3;

			if (n_ext > SMAX) n_s5 <= tgn_pkg::OUT_W'(SMAX);
			else if (n_ext < SMIN) n_s5 <= tgn_pkg::OUT_W'(SMIN);
			else n_s5 <= tgn_pkg::OUT_W'(n_ext);
		end
	end

	assign noise = n_s5;
endmodule

// ===== src/tiled_gradient_noise_2d.sv =====
// Channel  | Dir | Payload                      | Handshake
// point    | in  | coord_x[31:0], coord_y[31:0] | valid / ready
// result   | out | noise_value[18:0] signed     | valid / ready
// cfg      | in  | cfg_wdata[8:0] (tile width)  | cfg_we, no wait
//
// One item is accepted per cycle while no result waits untaken.
// The pipeline is the remainder stages (four index bits a stage), the three hash
// stages behind them and the five blend stages; the three fade stages run alongside.
// Reset empties the pipeline and sets the tile width to 5.
// While a result waits untaken, the whole pipeline holds and point.ready stays low.
`include "tiled_gradient_noise_2d_assert.svh"

module tiled_gradient_noise_2d #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tgn_point_if.sink                  point,
	tgn_result_if.source               result,
	input  logic                       cfg_we,
	input  logic [tgn_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int CW  = INT_BITS + FRAC_BITS;
	// Remainder stages, then wrap, first lookup and second lookup of the hash, then the blend.
	localparam int D   = (INT_BITS + 3) / 4;
	localparam int LAT = D + 8;

	logic [tgn_pkg::CFG_W-1:0] tile_q;
	logic [LAT-1:0]            vld_s;
	logic                      en;

	logic [CW-1:0]        cx, cy;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [INT_BITS-1:0]  ix, iy;
	logic [7:0]           x0, y0;
	logic [FRAC_BITS:0]   wx, wy;
	tgn_pkg::hash4_t      hash;

	// Fractions wait for the hashes; fades wait for the remainder stages.
	logic [FRAC_BITS-1:0] fx_dly_s [D+3];
	logic [FRAC_BITS-1:0] fy_dly_s [D+3];
	logic [FRAC_BITS:0]   wx_dly_s [D];
	logic [FRAC_BITS:0]   wy_dly_s [D];

	// The pipeline moves as one; it holds only while the output register is full
	// and the sink does not take the item.
	assign en          = result.ready || !result.valid;
	assign point.ready = en;

	// Bits above INT_BITS+FRAC_BITS are dropped; missing ones read as zero.
	assign cx = CW'(point.coord_x);
	assign cy = CW'(point.coord_y);
	assign fx = cx[FRAC_BITS-1:0];
	assign fy = cy[FRAC_BITS-1:0];
	assign ix = cx[CW-1:FRAC_BITS];
	assign iy = cy[CW-1:FRAC_BITS];

	// The tile width is stored already clamped to 1..256.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= tgn_pkg::TILE_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < tgn_pkg::TILE_MIN) tile_q <= tgn_pkg::TILE_MIN;
			else if (cfg_wdata > tgn_pkg::TILE_MAX) tile_q <= tgn_pkg::TILE_MAX;
			else tile_q <= cfg_wdata;
		end
	end

	// Valid bits travel beside the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], point.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_dly_s[0] <= fx;
			fy_dly_s[0] <= fy;
			for (int i = 1; i < D + 3; i++) begin
				fx_dly_s[i] <= fx_dly_s[i-1];
				fy_dly_s[i] <= fy_dly_s[i-1];
			end
			wx_dly_s[0] <= wx;
			wy_dly_s[0] <= wy;
			for (int i = 1; i < D; i++) begin
				wx_dly_s[i] <= wx_dly_s[i-1];
				wy_dly_s[i] <= wy_dly_s[i-1];
			end
		end
	end

	tgn_mod #(.IW(INT_BITS)) u_mod_x (
		.clk(clk), .en(en), .tile_w(tile_q), .idx(ix), .rem(x0)
	);

	tgn_mod #(.IW(INT_BITS)) u_mod_y (
		.clk(clk), .en(en), .tile_w(tile_q), .idx(iy), .rem(y0)
	);

	tgn_fade #(.F(FRAC_BITS)) u_fade_x (
		.clk(clk), .en(en), .t(fx), .fade(wx)
	);

	tgn_fade #(.F(FRAC_BITS)) u_fade_y (
		.clk(clk), .en(en), .t(fy), .fade(wy)
	);

	tgn_hash u_hash (
		.clk(clk), .en(en), .tile_w(tile_q), .x0(x0), .y0(y0), .hash(hash)
	);

	tgn_blend #(.F(FRAC_BITS)) u_blend (
		.clk(clk),
		.en(en),
		.hash(hash),
		.fx(fx_dly_s[D+2]),
		.fy(fy_dly_s[D+2]),
		.wx(wx_dly_s[D-1]),
		.wy(wy_dly_s[D-1]),
		.noise(result.noise_value)
	);

	assign result.valid = vld_s[LAT-1];

	// An accepted item always occupies the first stage afterwards.
	`TGN_ASSERT_NEXT(a_accept_enters, clk, arst_n, point.valid && point.ready, vld_s[0])
	// A write never leaves the tile width outside 1..256.
	`TGN_ASSERT_NEXT(a_tile_range, clk, arst_n, cfg_we, tile_q != 9'd0 && tile_q <= 9'd256)
	// A held result keeps its value while the pipeline is frozen.
	`TGN_ASSERT_NEXT(a_hold_result, clk, arst_n, !en, result.valid && $stable(result.noise_value))
endmodule

// ===== verif/tgn_tb_pkg.sv =====
`timescale 1ns / 100ps
package tgn_tb_pkg;

	// The testbench takes the permutation table from the design package;
	// this file only holds the stimulus channel item type.
	typedef struct {
		logic [31:0] coord_x;
		logic [31:0] coord_y;
	} point_item_t;

endpackage

// ===== verif/tiled_gradient_noise_2d_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the tiled 2D gradient noise block.
// Points are driven on the point channel at the falling clock edge and results
// are sampled at the rising edge. A predictor computes the fixed-point noise
// value of each accepted point from the tile width last written, and each
// result is compared with the oldest prediction.
module tiled_gradient_noise_2d_tb;

	localparam int FRAC = 16;
	localparam longint ONE_Q = 64'sd1 << FRAC;
	localparam int LATENCY = 12;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tgn_pkg::CFG_W-1:0] cfg_wdata = '0;

	tgn_point_if point ();
	tgn_result_if result ();

	tiled_gradient_noise_2d dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point.sink),
		.result(result.source),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the tile width as last written; the predictor clamps it when used.
	logic [tgn_pkg::CFG_W-1:0] tile_width_q;
	logic signed [tgn_pkg::OUT_W-1:0] noise_queue[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	int hold_cycles = 0;
	bit rx_random = 1'b1;

	function automatic longint floor_frac(longint v);
		return v >>> FRAC;
	endfunction

	function automatic longint fade(longint t);
		longint s, c, p;
		s = (t * t) >> FRAC;
		c = (s * t) >> FRAC;
		p = 6 * s + 10 * ONE_Q - 15 * t;
		return (c * p) >> FRAC;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a + floor_frac(w * (b - a));
	endfunction

	function automatic longint corner_dot(int h, longint dx, longint dy);
		longint u, v;
		u = (h[3:0] < 8) ? dx : dy;
		v = (h[3:0] < 4) ? dy : dx;
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic int corner_hash(int xi, int yi);
		return tgn_pkg::PERM[(int'(tgn_pkg::PERM[xi & 255]) + yi) & 255];
	endfunction

	function automatic logic signed [tgn_pkg::OUT_W-1:0] predict_noise(logic [31:0] px,
		logic [31:0] py);
		longint w, fx, fy, wx, wy, r0, r1, n;
		int x0, x1, y0, y1;
		w = tile_width_q;
		if (w == 0) w = 1;
		if (w > 256) w = 256;
		fx = px[15:0];
		fy = py[15:0];
		x0 = int'(longint'(px[31:16]) % w);
		y0 = int'(longint'(py[31:16]) % w);
		x1 = int'((x0 + 1) % w);
		y1 = int'((y0 + 1) % w);
		wx = fade(fx);
		wy = fade(fy);
		r0 = blend(corner_dot(corner_hash(x0, y0), fx, fy),
			corner_dot(corner_hash(x1, y0), fx - ONE_Q, fy), wx);
		r1 = blend(corner_dot(corner_hash(x0, y1), fx, fy - ONE_Q),
			corner_dot(corner_hash(x1, y1), fx - ONE_Q, fy - ONE_Q), wx);
		n = blend(r0, r1, wy);
		if (n > 262143) n = 262143;
		if (n < -262144) n = -262144;
		return n[tgn_pkg::OUT_W-1:0];
	endfunction

	// Prediction happens at the accepting edge, so the tile width is always the
	// one in force when the block took the item.
	always @(posedge clk) begin
		if (arst_n && point.valid && point.ready)
			noise_queue.push_back(predict_noise(point.coord_x, point.coord_y));
	end

	always @(posedge clk) begin
		logic signed [tgn_pkg::OUT_W-1:0] want;
		if (arst_n && result.valid && result.ready) begin
			if (noise_queue.size() == 0) begin
				$display("%0t: unexpected result, actual %0d", $time, result.noise_value);
				fail_count++;
			end else begin
				want = noise_queue.pop_front();
				if (want !== result.noise_value) begin
					$display("%0t: noise_value mismatch, expected %0d, actual %0d",
						$time, want, result.noise_value);
					fail_count++;
				end
			end
		end
	end

	// Receiver: a stall pattern of its own, plus a long forced hold-off.
	initial result.ready = 1'b0;
	always @(negedge clk) begin
		if (hold_off) begin
			result.ready <= 1'b0;
			hold_cycles++;
			if (hold_cycles >= 200) begin
				hold_off = 1'b0;
				hold_cycles = 0;
			end
		end else if (rx_random)
			result.ready <= ($urandom_range(0, 3) != 0);
		else
			result.ready <= 1'b1;
	end

	// Watchdog on cycles in which nothing moves on either channel.
	always @(posedge clk) begin
		if ((point.valid && point.ready) || (result.valid && result.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		point.valid = 1'b0;
		point.coord_x = '0;
		point.coord_y = '0;
	end

	// Sends one item; a following item keeps valid high without a drop.
	task automatic send_point(logic [31:0] px, logic [31:0] py);
		point.valid <= 1'b1;
		point.coord_x <= px;
		point.coord_y <= py;
		@(posedge clk);
		while (!point.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic go_idle();
		point.valid <= 1'b0;
	endtask

	// Lets every expected result arrive and the pipeline drain.
	task automatic drain();
		go_idle();
		while (noise_queue.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_tile_width(logic [tgn_pkg::CFG_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tile_width_q = val;
	endtask

	function automatic logic [31:0] random_coord(bit small_ints);
		logic [31:0] c;
		c = $urandom;
		if (small_ints) c[31:16] = 16'($urandom_range(0, 600));
		return c;
	endfunction

	task automatic test_directed_extremes();
		send_point(32'h0, 32'h0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h0000_8000, 32'h0000_8000);
		send_point(32'h0004_FFFF, 32'h0000_0001);
		send_point(32'h0005_0000, 32'h0009_0000);
		send_point(32'hAAAA_5555, 32'h5555_AAAA);
		send_point(32'h0001_0000, 32'hFFFF_0000);
		send_point(32'h0000_FFFF, 32'h0000_0000);
		drain();
	endtask

	// Walks the tile widths, the extremes and the out-of-range codes included.
	task automatic test_tile_widths();
		logic [tgn_pkg::CFG_W-1:0] widths[8] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd300, 9'd2,
			9'd255, 9'd17};
		foreach (widths[i]) begin
			write_tile_width(widths[i]);
			for (int k = 0; k < 8; k++)
				send_point(random_coord(k < 4), random_coord(k < 4));
			send_point(32'hFFFF_FFFF, 32'h0000_0000);
		end
		drain();
	endtask

	// Random points in bursts with gaps, under a few widths.
	task automatic test_random_points(int count);
		int sent = 0;
		tgn_tb_pkg::point_item_t pt;
		while (sent < count) begin
			int burst = $urandom_range(1, 20);
			if (sent % 300 < 20) write_tile_width(9'($urandom_range(0, 511)));
			for (int k = 0; k < burst && sent < count; k++) begin
				pt.coord_x = random_coord(1'($urandom_range(0, 1)));
				pt.coord_y = random_coord(1'($urandom_range(0, 1)));
				send_point(pt.coord_x, pt.coord_y);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				go_idle();
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	// The receiver holds off while points keep coming, so the input stalls.
	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int k = 0; k < 60; k++)
			send_point(random_coord(1), random_coord(0));
		drain();
		rx_random = 1'b0;
		for (int k = 0; k < 40; k++)
			send_point(random_coord(0), random_coord(1));
		drain();
		rx_random = 1'b1;
	endtask

	initial begin
		tile_width_q = tgn_pkg::TILE_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_extremes();
		test_tile_widths();
		test_backpressure();
		test_random_points(1250);
		drain();
		if (fail_count == 0 && noise_queue.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== tiled_gradient_noise_2d.f =====
+incdir+src
src/tgn_pkg.sv
src/tgn_point_if.sv
src/tgn_result_if.sv
src/tgn_mod.sv
src/tgn_fade.sv
src/tgn_hash.sv
src/tgn_blend.sv
src/tiled_gradient_noise_2d.sv
verif/tgn_tb_pkg.sv
verif/tiled_gradient_noise_2d_tb.sv
